>>> hw/rtl/wcc_pkg.sv
// wcc_pkg: shared types and constants of the window co-occurrence counter
// used by wcc_ctrl, wcc_datapath and window_cooccurrence_counter; no dependencies
`timescale 1ns / 1ps

package wcc_pkg;

    localparam int ID_W    = 8;
    localparam int CNT_W   = 32;
    localparam int DIST_W  = 17;
    localparam int WORDS_W = 48;

    localparam logic [CNT_W-1:0]   COUNT_MAX    = '1;
    localparam logic [DIST_W-1:0]  DISTINCT_MAX = '1;
    localparam logic [WORDS_W-1:0] WORDS_MAX    = '1;

    // one window entry: bnd set means boundary marker
    typedef struct packed {
        logic            bnd;
        logic [ID_W-1:0] id;
    } wcc_entry_t;

    localparam wcc_entry_t BOUNDARY_ENTRY = '{bnd: 1'b1, id: '0};

    // controller to datapath
    typedef struct packed {
        logic push;        // accept one input beat, shift the window
        logic issue;       // launch one pair slot into the update pipe
        logic issue_last;  // the launched slot is the final one of its item
        logic clear_step;  // zero one count entry
    } wcc_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic s1_free;     // update stage can take a slot this cycle
        logic clear_last;  // clear pointer is at the final entry
    } wcc_status_t;

endpackage

>>> hw/rtl/wcc_ram.sv
// wcc_ram: generic single-write, single-read RAM with registered read data
// no dependencies
`timescale 1ns / 1ps

module wcc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (rd_en) begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> hw/rtl/wcc_ctrl.sv
// wcc_ctrl: sequencer for the co-occurrence counter (clear sweep, input
// acceptance, pair slot issue); depends on wcc_pkg
`timescale 1ns / 1ps

module wcc_ctrl
    import wcc_pkg::*;
#(
    parameter int WINDOW = 5,
    localparam int NSLOT = 2 * (WINDOW - 1),
    localparam int SW    = (NSLOT > 1) ? $clog2(NSLOT) : 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  wcc_status_t       status,
    output wcc_cmd_t          cmd,
    output logic [SW-1:0]     slot
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t        state_reg, state_next;
    logic [SW-1:0] slot_reg, slot_next;
    logic          issue, at_last, push;

    always_comb begin
        issue   = (state_reg == ST_RUN) && status.s1_free;
        at_last = (slot_reg == SW'(NSLOT - 1));
        // next beat may enter in the cycle the final slot leaves
        s_ready = (state_reg == ST_IDLE) || (issue && at_last);
        push    = s_valid && s_ready;

        cmd.push       = push;
        cmd.issue      = issue;
        cmd.issue_last = issue && at_last;
        cmd.clear_step = (state_reg == ST_CLEAR);
        slot           = slot_reg;

        state_next = state_reg;
        slot_next  = slot_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (status.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (push) begin
                    state_next = ST_RUN;
                    slot_next  = '0;
                end
            end
            ST_RUN: begin
                if (issue) begin
                    if (at_last) begin
                        slot_next  = '0;
                        state_next = push ? ST_RUN : ST_IDLE;
                    end else begin
                        slot_next = slot_reg + SW'(1);
                    end
                end
            end
            default: begin
                state_next = ST_CLEAR;
                slot_next  = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            slot_reg  <= '0;
        end else begin
            state_reg <= state_next;
            slot_reg  <= slot_next;
        end
    end

endmodule

>>> hw/rtl/wcc_datapath.sv
// wcc_datapath: window shift line, count memory read-modify-write pipe,
// running totals and output register; depends on wcc_pkg and wcc_ram
`timescale 1ns / 1ps

module wcc_datapath
    import wcc_pkg::*;
#(
    parameter int WINDOW = 5,
    parameter int VOCAB  = 256,
    localparam int NSLOT = 2 * (WINDOW - 1),
    localparam int SW    = (NSLOT > 1) ? $clog2(NSLOT) : 1,
    localparam int JW    = $clog2(WINDOW),
    localparam int DEPTH = VOCAB * VOCAB,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  wcc_cmd_t            cmd,
    input  logic [SW-1:0]       slot,
    output wcc_status_t         status,
    input  logic [ID_W-1:0]     s_word_id,
    input  logic                s_is_boundary,
    input  logic                s_is_flush,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_pair_valid,
    output logic [ID_W-1:0]     m_row_id,
    output logic [ID_W-1:0]     m_col_id,
    output logic [CNT_W-1:0]    m_pair_count,
    output logic                m_first_seen,
    output logic [DIST_W-1:0]   m_distinct_pairs,
    output logic [WORDS_W-1:0]  m_words_seen,
    output logic                m_last
);

    // window, oldest at index 0
    wcc_entry_t win_reg [WINDOW];
    logic [WORDS_W-1:0] words_reg;
    logic [DIST_W-1:0]  dist_reg, dist_next;
    logic [AW-1:0]      clr_reg;

    // update stage
    logic               s1_valid_reg;
    logic               s1_ok_reg;
    logic [ID_W-1:0]    s1_row_reg, s1_col_reg;
    logic [AW-1:0]      s1_addr_reg;
    logic               s1_last_reg;
    logic               s1_fwd_reg;
    logic [CNT_W-1:0]   s1_fwd_data_reg;
    logic [WORDS_W-1:0] s1_words_reg;

    // output register
    logic               m_valid_reg;
    logic               m_pair_valid_reg, m_first_seen_reg, m_last_reg;
    logic [ID_W-1:0]    m_row_id_reg, m_col_id_reg;
    logic [CNT_W-1:0]   m_pair_count_reg;
    logic [DIST_W-1:0]  m_distinct_pairs_reg;
    logic [WORDS_W-1:0] m_words_seen_reg;

    logic [JW-1:0]    j_idx;
    wcc_entry_t       e_row, e_col;
    logic             pair_ok;
    logic [AW-1:0]    issue_addr;
    logic             out_free, retire;
    logic [CNT_W-1:0] rdata, base, new_count;
    logic             fresh;
    logic             ram_we, ram_rd;
    logic [AW-1:0]    ram_waddr;
    logic [CNT_W-1:0] ram_wdata;
    wcc_entry_t       new_entry;

    function automatic logic is_word(wcc_entry_t e);
        return !e.bnd && (32'(e.id) < VOCAB);
    endfunction

    always_comb begin
        j_idx = JW'(slot >> 1) + JW'(1);
        // even slot: (oldest, later), odd slot: (later, oldest)
        if (slot[0]) begin
            e_row = win_reg[j_idx];
            e_col = win_reg[0];
        end else begin
            e_row = win_reg[0];
            e_col = win_reg[j_idx];
        end
        pair_ok    = is_word(e_row) && is_word(e_col);
        issue_addr = AW'(e_row.id) * AW'(VOCAB) + AW'(e_col.id);

        out_free = !m_valid_reg || m_ready;
        retire   = s1_valid_reg && out_free;

        base      = s1_fwd_reg ? s1_fwd_data_reg : rdata;
        fresh     = s1_ok_reg && (base == '0);
        new_count = (base == COUNT_MAX) ? COUNT_MAX : base + CNT_W'(1);
        dist_next = (retire && fresh && dist_reg != DISTINCT_MAX) ?
                    dist_reg + DIST_W'(1) : dist_reg;

        ram_rd    = cmd.issue && pair_ok;
        ram_we    = cmd.clear_step || (retire && s1_ok_reg);
        ram_waddr = cmd.clear_step ? clr_reg : s1_addr_reg;
        ram_wdata = cmd.clear_step ? '0 : new_count;

        if (s_is_boundary || s_is_flush) begin
            new_entry = BOUNDARY_ENTRY;
        end else begin
            new_entry = '{bnd: 1'b0, id: s_word_id};
        end

        status.s1_free    = !s1_valid_reg || out_free;
        status.clear_last = (clr_reg == AW'(DEPTH - 1));
    end

    wcc_ram #(
        .WIDTH(CNT_W),
        .DEPTH(DEPTH)
    ) u_count_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .rd_en (ram_rd),
        .raddr (issue_addr),
        .rdata (rdata)
    );

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WINDOW; i++) begin
                win_reg[i] <= BOUNDARY_ENTRY;
            end
            words_reg    <= '0;
            dist_reg     <= '0;
            clr_reg      <= '0;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cmd.clear_step && !status.clear_last) begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (cmd.push) begin
                for (int i = 0; i < WINDOW - 1; i++) begin
                    win_reg[i] <= win_reg[i+1];
                end
                win_reg[WINDOW-1] <= new_entry;
                if (!s_is_flush && words_reg != WORDS_MAX) begin
                    words_reg <= words_reg + WORDS_W'(1);
                end
            end
            dist_reg <= dist_next;
            if (cmd.issue) begin
                s1_valid_reg <= 1'b1;
            end else if (retire) begin
                s1_valid_reg <= 1'b0;
            end
            if (retire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.issue) begin
            s1_ok_reg       <= pair_ok;
            s1_row_reg      <= e_row.id;
            s1_col_reg      <= e_col.id;
            s1_addr_reg     <= issue_addr;
            s1_last_reg     <= cmd.issue_last;
            s1_words_reg    <= words_reg;
            // the ram returns old data when the retiring slot writes this address
            s1_fwd_reg      <= retire && s1_ok_reg && (s1_addr_reg == issue_addr);
            s1_fwd_data_reg <= new_count;
        end
        if (retire) begin
            m_pair_valid_reg     <= s1_ok_reg;
            m_row_id_reg         <= s1_ok_reg ? s1_row_reg : '0;
            m_col_id_reg         <= s1_ok_reg ? s1_col_reg : '0;
            m_pair_count_reg     <= s1_ok_reg ? new_count : '0;
            m_first_seen_reg     <= fresh;
            m_distinct_pairs_reg <= dist_next;
            m_words_seen_reg     <= s1_words_reg;
            m_last_reg           <= s1_last_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_pair_valid     = m_pair_valid_reg;
    assign m_row_id         = m_row_id_reg;
    assign m_col_id         = m_col_id_reg;
    assign m_pair_count     = m_pair_count_reg;
    assign m_first_seen     = m_first_seen_reg;
    assign m_distinct_pairs = m_distinct_pairs_reg;
    assign m_words_seen     = m_words_seen_reg;
    assign m_last           = m_last_reg;

endmodule

>>> hw/rtl/window_cooccurrence_counter.sv
// window_cooccurrence_counter: top level, ties the sequencer to the datapath
// depends on wcc_pkg, wcc_ctrl, wcc_datapath (and wcc_ram below it)
//
// Usage:
//   s_ channel: one beat per token (word id, sentence boundary or flush pad).
//   m_ channel: 2*(WINDOW-1) beats per input beat, one per ordered pair slot,
//   m_last high on the final one. Skipped slots come out with m_pair_valid low.
//   Each slot is one read-modify-write of the count RAM, pipelined with
//   read-after-write forwarding, so a slot can issue while the one before it
//   is in the update stage, and the next beat is taken in the cycle its
//   final slot issues. Results go via the update stage to the output register.
//   Reset: the window fills with boundaries and the totals clear, then a
//   sweep zeroes all VOCAB*VOCAB count RAM entries (65536 at VOCAB=256),
//   one entry a cycle; s_ready stays low until it finishes.
//   Stall: when m_ready is low the result waits in the output register, one
//   more slot waits in the update stage, and slot issue pauses until the
//   output register drains.
`timescale 1ns / 1ps

module window_cooccurrence_counter
    import wcc_pkg::*;
#(
    parameter int WINDOW = 5,
    parameter int VOCAB  = 256
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [ID_W-1:0]    s_word_id,
    input  logic               s_is_boundary,
    input  logic               s_is_flush,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_pair_valid,
    output logic [ID_W-1:0]    m_row_id,
    output logic [ID_W-1:0]    m_col_id,
    output logic [CNT_W-1:0]   m_pair_count,
    output logic               m_first_seen,
    output logic [DIST_W-1:0]  m_distinct_pairs,
    output logic [WORDS_W-1:0] m_words_seen,
    output logic               m_last
);

    localparam int NSLOT = 2 * (WINDOW - 1);
    localparam int SW    = (NSLOT > 1) ? $clog2(NSLOT) : 1;

    wcc_cmd_t      cmd;
    wcc_status_t   status;
    logic [SW-1:0] slot;

    wcc_ctrl #(
        .WINDOW(WINDOW)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd),
        .slot    (slot)
    );

    wcc_datapath #(
        .WINDOW(WINDOW),
        .VOCAB (VOCAB)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .slot             (slot),
        .status           (status),
        .s_word_id        (s_word_id),
        .s_is_boundary    (s_is_boundary),
        .s_is_flush       (s_is_flush),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_pair_valid     (m_pair_valid),
        .m_row_id         (m_row_id),
        .m_col_id         (m_col_id),
        .m_pair_count     (m_pair_count),
        .m_first_seen     (m_first_seen),
        .m_distinct_pairs (m_distinct_pairs),
        .m_words_seen     (m_words_seen),
        .m_last           (m_last)
    );

    // a slot only launches when the update stage can take it
    a_issue_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.issue |-> status.s1_free)
        else $error("slot issued into a busy update stage");

    // no input beat during the clear sweep
    a_no_push_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear_step |-> !s_ready)
        else $error("input accepted while count ram is clearing");

    // a new beat overlaps only the final slot of the previous item
    a_push_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push && cmd.issue |-> cmd.issue_last)
        else $error("window shifted while slots still pending");

    // a counted pair always reports a count of at least one
    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_pair_valid |-> m_pair_count != '0)
        else $error("counted pair reports zero count");

endmodule
